>>> src/twcc_pkg.sv
`timescale 1ns / 1ps

package twcc_pkg;

  // Field widths of the ports.
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BELL_ENABLE   = 3'd5;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CH_BEL   = 8'd7;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  // Input opcodes.
  localparam logic OPC_PUT_CHAR = 1'b0;
  localparam logic OPC_SET_CUR  = 1'b1;

  // Display commands.
  typedef enum logic [1:0] {
    CMD_MOVE   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SCROLL = 2'd2,
    CMD_BELL   = 2'd3
  } cmd_e;

  // Classified operation kinds passed from front to back.
  typedef enum logic [2:0] {
    OP_SET,
    OP_BEL,
    OP_CR,
    OP_LF,
    OP_TAB,
    OP_BS,
    OP_PUT
  } op_kind_e;

  // Back sequencer states.
  typedef enum logic {
    BK_RUN,
    BK_SCROLL
  } bk_state_e;

  typedef struct packed {
    op_kind_e          kind;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } op_t;

  typedef struct packed {
    logic [ROW_W-1:0]  top;
    logic [ROW_W-1:0]  bottom;
    logic [COL_W-1:0]  left;
    logic [COL_W-1:0]  right;
    logic [ATTR_W-1:0] attr;
    logic              bell;
  } cfg_t;

  typedef struct packed {
    cmd_e              command;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              last;
  } result_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

>>> src/twcc_front.sv
`timescale 1ns / 1ps

module twcc_front #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80
) (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [twcc_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [twcc_pkg::ROW_W-1:0]    set_row_i,
  input  logic [twcc_pkg::COL_W-1:0]    set_col_i,
  input  twcc_pkg::q_status_t           q_status_i,
  output logic                          push_o,
  output twcc_pkg::op_t                 op_o
);

  localparam logic [twcc_pkg::ROW_W-1:0] RowMax = twcc_pkg::ROW_W'(SCREEN_ROWS - 1);
  localparam logic [twcc_pkg::COL_W-1:0] ColMax = twcc_pkg::COL_W'(SCREEN_COLS - 1);

  // A word is taken whenever the queue has room.
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i & ~q_status_i.full;

  // Classify the word and clamp a requested cursor position to the screen.
  always_comb begin
    op_o.ch  = char_code_i;
    op_o.row = (set_row_i > RowMax) ? RowMax : set_row_i;
    op_o.col = (set_col_i > ColMax) ? ColMax : set_col_i;
    if (opcode_i == twcc_pkg::OPC_SET_CUR) begin
      op_o.kind = twcc_pkg::OP_SET;
    end else begin
      case (char_code_i)
        twcc_pkg::CH_BEL: op_o.kind = twcc_pkg::OP_BEL;
        twcc_pkg::CH_CR:  op_o.kind = twcc_pkg::OP_CR;
        twcc_pkg::CH_LF:  op_o.kind = twcc_pkg::OP_LF;
        twcc_pkg::CH_TAB: op_o.kind = twcc_pkg::OP_TAB;
        twcc_pkg::CH_BS:  op_o.kind = twcc_pkg::OP_BS;
        default:          op_o.kind = twcc_pkg::OP_PUT;
      endcase
    end
  end

endmodule

>>> src/twcc_queue.sv
`timescale 1ns / 1ps

module twcc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  twcc_pkg::op_t       op_i,
  input  logic                pop_i,
  output twcc_pkg::q_status_t status_o,
  output twcc_pkg::op_t       head_o
);

  twcc_pkg::op_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.valid = (count_q != 2'd0);
  assign head_o         = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

>>> src/twcc_back.sv
`timescale 1ns / 1ps

module twcc_back #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80,
  parameter int TAB_SPACES  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  twcc_pkg::cfg_t      cfg_i,
  input  logic                head_valid_i,
  input  twcc_pkg::op_t       head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output twcc_pkg::result_t   result_o
);

  localparam int RowW = twcc_pkg::ROW_W;
  localparam int ColW = twcc_pkg::COL_W;
  localparam int TabW = $clog2(TAB_SPACES + 1);
  localparam logic [RowW-1:0] RowMax = RowW'(SCREEN_ROWS - 1);
  localparam logic [ColW-1:0] ColMax = ColW'(SCREEN_COLS - 1);

  twcc_pkg::bk_state_e state_q, state_d;
  logic [RowW-1:0] cur_row_q, cur_row_d;
  logic [ColW-1:0] cur_col_q, cur_col_d;
  logic [TabW-1:0] tab_cnt_q, tab_cnt_d;
  logic            out_valid_q, out_valid_d;
  twcc_pkg::result_t res_q, res_d;

  logic            slot_free;
  logic            fire;
  logic [RowW:0]   row_sum;
  logic [ColW:0]   col_sum;
  logic [RowW-1:0] row_down;
  logic [ColW-1:0] col_right;
  logic [twcc_pkg::CHAR_W-1:0] put_ch;
  logic            tab_final_write;
  logic            tab_final_scroll;

  // Saturating steps of the cursor.
  assign row_sum   = {1'b0, cur_row_q} + {{RowW{1'b0}}, 1'b1};
  assign col_sum   = {1'b0, cur_col_q} + {{ColW{1'b0}}, 1'b1};
  assign row_down  = (row_sum > {1'b0, RowMax}) ? RowMax : row_sum[RowW-1:0];
  assign col_right = (col_sum > {1'b0, ColMax}) ? ColMax : col_sum[ColW-1:0];

  assign put_ch = (head_i.kind == twcc_pkg::OP_TAB) ? twcc_pkg::CH_SPACE : head_i.ch;
  assign tab_final_write  = (tab_cnt_q == TabW'(TAB_SPACES - 1));
  assign tab_final_scroll = (tab_cnt_q == TabW'(TAB_SPACES));

  // One result is produced per cycle whenever an item is queued and the output register can take it.
  assign slot_free   = ~out_valid_q | ~out_stall_i;
  assign fire        = head_valid_i & slot_free;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // Sequencer: next state, cursor update and the result word.
  always_comb begin
    state_d   = state_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    tab_cnt_d = tab_cnt_q;
    pop_o     = 1'b0;

    res_d            = res_q;
    res_d.command    = twcc_pkg::CMD_MOVE;
    res_d.cell_row   = '0;
    res_d.cell_col   = '0;
    res_d.cell_char  = '0;
    res_d.cell_attr  = '0;
    res_d.last       = 1'b1;

    if (state_q == twcc_pkg::BK_SCROLL) begin
      // Scroll that follows a write at the bottom right corner.
      res_d.command   = twcc_pkg::CMD_SCROLL;
      res_d.cell_row  = cfg_i.top;
      res_d.cell_col  = cfg_i.left;
      res_d.cell_char = twcc_pkg::CH_SPACE;
      res_d.cell_attr = cfg_i.attr;
      res_d.last      = (head_i.kind != twcc_pkg::OP_TAB) || tab_final_scroll;
      state_d         = twcc_pkg::BK_RUN;
    end else begin
      case (head_i.kind)
        twcc_pkg::OP_SET: begin
          cur_row_d = head_i.row;
          cur_col_d = head_i.col;
        end
        twcc_pkg::OP_BEL: begin
          res_d.command = cfg_i.bell ? twcc_pkg::CMD_BELL : twcc_pkg::CMD_MOVE;
        end
        twcc_pkg::OP_CR: begin
          cur_col_d = cfg_i.left;
        end
        twcc_pkg::OP_LF: begin
          if (cur_row_q == cfg_i.bottom) begin
            res_d.command   = twcc_pkg::CMD_SCROLL;
            res_d.cell_row  = cfg_i.top;
            res_d.cell_col  = cfg_i.left;
            res_d.cell_char = twcc_pkg::CH_SPACE;
            res_d.cell_attr = cfg_i.attr;
          end else begin
            cur_row_d = row_down;
          end
        end
        twcc_pkg::OP_BS: begin
          if (cur_col_q == cfg_i.left || cur_col_q == '0) begin
            if (!(cur_row_q == cfg_i.top || cur_row_q == '0)) begin
              cur_row_d       = cur_row_q - {{(RowW-1){1'b0}}, 1'b1};
              cur_col_d       = cfg_i.right;
              res_d.command   = twcc_pkg::CMD_WRITE;
              res_d.cell_row  = cur_row_d;
              res_d.cell_col  = cfg_i.right;
              res_d.cell_char = twcc_pkg::CH_SPACE;
              res_d.cell_attr = cfg_i.attr;
            end
          end else begin
            cur_col_d       = cur_col_q - {{(ColW-1){1'b0}}, 1'b1};
            res_d.command   = twcc_pkg::CMD_WRITE;
            res_d.cell_row  = cur_row_q;
            res_d.cell_col  = cur_col_d;
            res_d.cell_char = twcc_pkg::CH_SPACE;
            res_d.cell_attr = cfg_i.attr;
          end
        end
        default: begin
          // Printable character, or one space of a tab.
          res_d.command   = twcc_pkg::CMD_WRITE;
          res_d.cell_row  = cur_row_q;
          res_d.cell_col  = cur_col_q;
          res_d.cell_char = put_ch;
          res_d.cell_attr = cfg_i.attr;
          if (head_i.kind == twcc_pkg::OP_TAB) begin
            tab_cnt_d = tab_cnt_q + {{(TabW-1){1'b0}}, 1'b1};
          end
          res_d.last = (head_i.kind != twcc_pkg::OP_TAB) || tab_final_write;
          if (cur_col_q == cfg_i.right) begin
            cur_col_d = cfg_i.left;
            if (cur_row_q == cfg_i.bottom) begin
              state_d    = twcc_pkg::BK_SCROLL;
              res_d.last = 1'b0;
            end else begin
              cur_row_d = row_down;
            end
          end else begin
            cur_col_d = col_right;
          end
        end
      endcase
    end

    res_d.cursor_row = cur_row_d;
    res_d.cursor_col = cur_col_d;

    if (res_d.last) begin
      pop_o     = fire;
      tab_cnt_d = '0;
    end

    // Nothing moves unless a result is produced this cycle.
    if (!fire) begin
      state_d   = state_q;
      cur_row_d = cur_row_q;
      cur_col_d = cur_col_q;
      tab_cnt_d = tab_cnt_q;
      pop_o     = 1'b0;
    end

    out_valid_d = fire | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twcc_pkg::BK_RUN;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      tab_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      tab_cnt_q   <= tab_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

endmodule

>>> src/text_window_cursor_control_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o  opcode, char_code, set_row, set_col
// output    out        out_valid_o / out_stall_i command, cell_*, cursor_*, last
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The back end produces one result word per cycle while the output is not stalled. An item has
// one result in most cases, two for a write that scrolls, up to 2*TAB_SPACES for tab.
// An accepted word is written into the queue and, once the back end takes it, its first result
// is in the output register.
// A two-entry queue separates input and back end; the input stalls only while both are taken.
// Reset clears the cursor to the top-left corner and loads the register reset values.

module text_window_cursor_control_core #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80,
  parameter int TAB_SPACES  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic [twcc_pkg::CHAR_W-1:0]       char_code_i,
  input  logic [twcc_pkg::ROW_W-1:0]        set_row_i,
  input  logic [twcc_pkg::COL_W-1:0]        set_col_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        command_o,
  output logic [twcc_pkg::ROW_W-1:0]        cell_row_o,
  output logic [twcc_pkg::COL_W-1:0]        cell_col_o,
  output logic [twcc_pkg::CHAR_W-1:0]       cell_char_o,
  output logic [twcc_pkg::ATTR_W-1:0]       cell_attr_o,
  output logic [twcc_pkg::ROW_W-1:0]        cursor_row_o,
  output logic [twcc_pkg::COL_W-1:0]        cursor_col_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [twcc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [twcc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  twcc_pkg::cfg_t      cfg_q, cfg_d;
  twcc_pkg::q_status_t q_status;
  twcc_pkg::op_t       push_op;
  twcc_pkg::op_t       head_op;
  twcc_pkg::result_t   result;
  logic                push;
  logic                pop;
  logic                cfg_write;

  // Configuration registers are always ready.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (cfg_index_i)
        twcc_pkg::CFG_WINDOW_TOP:    cfg_d.top    = cfg_data_i[twcc_pkg::ROW_W-1:0];
        twcc_pkg::CFG_WINDOW_BOTTOM: cfg_d.bottom = cfg_data_i[twcc_pkg::ROW_W-1:0];
        twcc_pkg::CFG_WINDOW_LEFT:   cfg_d.left   = cfg_data_i[twcc_pkg::COL_W-1:0];
        twcc_pkg::CFG_WINDOW_RIGHT:  cfg_d.right  = cfg_data_i[twcc_pkg::COL_W-1:0];
        twcc_pkg::CFG_TEXT_ATTR:     cfg_d.attr   = cfg_data_i;
        twcc_pkg::CFG_BELL_ENABLE:   cfg_d.bell   = cfg_data_i[0];
        default:                     cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.top    <= 5'd0;
      cfg_q.bottom <= 5'd24;
      cfg_q.left   <= 7'd0;
      cfg_q.right  <= 7'd79;
      cfg_q.attr   <= 8'd7;
      cfg_q.bell   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  twcc_front #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .char_code_i (char_code_i),
    .set_row_i   (set_row_i),
    .set_col_i   (set_col_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .op_o        (push_op)
  );

  twcc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .op_i     (push_op),
    .pop_i    (pop),
    .status_o (q_status),
    .head_o   (head_op)
  );

  twcc_back #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS),
    .TAB_SPACES  (TAB_SPACES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (q_status.valid),
    .head_i       (head_op),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign command_o    = result.command;
  assign cell_row_o   = result.cell_row;
  assign cell_col_o   = result.cell_col;
  assign cell_char_o  = result.cell_char;
  assign cell_attr_o  = result.cell_attr;
  assign cursor_row_o = result.cursor_row;
  assign cursor_col_o = result.cursor_col;
  assign last_o       = result.last;

endmodule
